// ----- hdl/kronecker_factored_matvec_core_defines.svh -----
// Assertion macros for the Kronecker matrix-vector core
`ifndef KRONECKER_FACTORED_MATVEC_CORE_DEFINES_SVH
`define KRONECKER_FACTORED_MATVEC_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define KFMV_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define KFMV_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define KFMV_ASSERT(label, clk, rst_n, prop)
`define KFMV_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- hdl/kfmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfmv_pkg
// Types and constants shared by the Kronecker matrix-vector core.
// ----------------------------------------------------------------------------
package kfmv_pkg;
	localparam int ROWS_A = 8;
	localparam int COLS_A = 32;
	localparam int ROWS_B = 2;
	localparam int COLS_B = 32;
	localparam int A_SIZE = ROWS_A * COLS_A;
	localparam int B_SIZE = ROWS_B * COLS_B;
	localparam int Y_SIZE = ROWS_A * ROWS_B;
	localparam int X_SIZE = COLS_A * COLS_B;
	localparam int P_SIZE = ROWS_A * COLS_B;
	localparam int AW = (A_SIZE > 1) ? $clog2(A_SIZE) : 1;
	localparam int BW = (B_SIZE > 1) ? $clog2(B_SIZE) : 1;
	localparam int YW = (Y_SIZE > 1) ? $clog2(Y_SIZE) : 1;
	localparam int XW = (X_SIZE > 1) ? $clog2(X_SIZE) : 1;
	localparam int PW = (P_SIZE > 1) ? $clog2(P_SIZE) : 1;
	localparam int RAW = (ROWS_A > 1) ? $clog2(ROWS_A) : 1;
	localparam int CAW = (COLS_A > 1) ? $clog2(COLS_A) : 1;
	localparam int RBW = (ROWS_B > 1) ? $clog2(ROWS_B) : 1;
	localparam int CBW = (COLS_B > 1) ? $clog2(COLS_B) : 1;

	typedef enum logic [1:0] {
		ACT_WR_A = 2'd0, ACT_WR_B = 2'd1, ACT_WR_BIAS = 2'd2, ACT_PUSH_X = 2'd3
	} action_t;

	localparam logic [1:0] REG_BIAS_EN = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE, ST_P_MAC, ST_P_DRAIN, ST_Y_MAC, ST_Y_DRAIN, ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic          p_mac;     // A*X term valid this cycle
		logic          p_clr;     // first term of a P sum
		logic          p_wr;      // write finished P sum
		logic [RAW-1:0] i;
		logic [CBW-1:0] j;
		logic [CAW-1:0] c;
		logic          y_mac;
		logic          y_clr;
		logic          y_fin;     // finish Y sum into output register
		logic [RBW-1:0] k;
		logic          out_take;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;
endpackage

// ----- hdl/kfmv_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfmv_in_if / kfmv_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface kfmv_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [9:0]         index;
	logic signed [15:0] value;
	logic               last_element;
	modport source (output valid, action, index, value, last_element, input ready);
	modport sink (input valid, action, index, value, last_element, output ready);
endinterface

interface kfmv_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic [3:0]         out_index;
	logic               last_result;
	modport source (output valid, result, out_index, last_result, input ready);
	modport sink (input valid, result, out_index, last_result, output ready);
endinterface

// ----- hdl/kronecker_factored_matvec_core.sv -----
`timescale 1ns / 1ps
// A marked push (a push with last_element) starts the work on one vector: the A*X pass and
// then the P*B^T pass, each on its own multiply-accumulate path.
// Writes and unmarked pushes are taken while the core is idle; input waits while a vector is worked.
// Results leave one at a time through a registered output stage.
// Reset: arst_n clears control state and bias_enable; stores keep undefined contents.
// ----------------------------------------------------------------------------
// kronecker_factored_matvec_core
// y = (A kron B) x, plus bias when bias_enable is set, computed as P = A*X then Y = P*B^T.
// ----------------------------------------------------------------------------
`include "kronecker_factored_matvec_core_defines.svh"
module kronecker_factored_matvec_core import kfmv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	kfmv_in_if.sink     in_ch,
	kfmv_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic bias_en_q, busy, acc, start;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bias_en_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == REG_BIAS_EN) bias_en_q <= pwdata[0];
	end
	assign prdata = (paddr == REG_BIAS_EN) ? {31'd0, bias_en_q} : 32'd0;

	assign in_ch.ready = !busy;
	assign acc = in_ch.valid && in_ch.ready;
	assign start = acc && in_ch.action == ACT_PUSH_X && in_ch.last_element;

	kfmv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .out_ready(out_ch.ready),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	kfmv_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .wr_en(acc), .wr_action(in_ch.action),
		.wr_index(in_ch.index), .wr_value(in_ch.value), .bias_en(bias_en_q),
		.cmd(cmd), .sts(sts), .out_valid(out_ch.valid), .out_result(out_ch.result),
		.out_idx(out_ch.out_index), .out_last(out_ch.last_result)
	);

	`KFMV_ASSERT(a_no_in_busy, clk, arst_n, busy |-> !in_ch.ready)
	`KFMV_ASSERT(a_start_busy, clk, arst_n, start |=> busy)
	`KFMV_ASSERT(a_fin_empty, clk, arst_n, cmd.y_fin |-> !out_ch.valid)
	`KFMV_ASSERT_RST(a_rst_idle, clk, !arst_n |=> !out_ch.valid)
endmodule

// ----- hdl/kfmv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfmv_ctrl
// Sequencer: walks the A*X and P*B^T loops and paces result beats.
// ----------------------------------------------------------------------------
module kfmv_ctrl import kfmv_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   out_ready,
	input  sts_t   sts,
	output logic   busy,
	output cmd_t   cmd
);
	state_t          state_q, state_nx;
	logic [RAW-1:0]  i_q, i_nx;
	logic [CBW-1:0]  j_q, j_nx;
	logic [CAW-1:0]  c_q, c_nx;
	logic [RBW-1:0]  k_q, k_nx;
	logic [1:0]      drain_q, drain_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0; j_q <= '0; c_q <= '0; k_q <= '0; drain_q <= '0;
		end else begin
			state_q <= state_nx;
			i_q <= i_nx; j_q <= j_nx; c_q <= c_nx; k_q <= k_nx; drain_q <= drain_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		i_nx = i_q; j_nx = j_q; c_nx = c_q; k_nx = k_q; drain_nx = drain_q;
		cmd = '0;
		cmd.i = i_q; cmd.j = j_q; cmd.c = c_q; cmd.k = k_q;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nx = ST_P_MAC;
					i_nx = '0; j_nx = '0; c_nx = '0;
				end
			end
			ST_P_MAC: begin
				cmd.p_mac = 1'b1;
				cmd.p_clr = (c_q == '0);
				if (c_q == CAW'(COLS_A - 1)) begin
					c_nx = '0;
					state_nx = ST_P_DRAIN;
					drain_nx = '0;
				end else begin
					c_nx = c_q + 1'b1;
				end
			end
			ST_P_DRAIN: begin
				// wait for read and product stages to empty into the sum
				drain_nx = drain_q + 1'b1;
				if (drain_q == 2'd2) begin
					cmd.p_wr = 1'b1;
					if (j_q == CBW'(COLS_B - 1)) begin
						j_nx = '0;
						if (i_q == RAW'(ROWS_A - 1)) begin
							i_nx = '0; k_nx = '0;
							state_nx = ST_Y_MAC;
						end else begin
							i_nx = i_q + 1'b1;
							state_nx = ST_P_MAC;
						end
					end else begin
						j_nx = j_q + 1'b1;
						state_nx = ST_P_MAC;
					end
				end
			end
			ST_Y_MAC: begin
				cmd.y_mac = 1'b1;
				cmd.y_clr = (j_q == '0);
				if (j_q == CBW'(COLS_B - 1)) begin
					j_nx = '0;
					drain_nx = '0;
					state_nx = ST_Y_DRAIN;
				end else begin
					j_nx = j_q + 1'b1;
				end
			end
			ST_Y_DRAIN: begin
				drain_nx = drain_q + 1'b1;
				if (drain_q == 2'd3 && !sts.out_full) begin
					cmd.y_fin = 1'b1;
					state_nx = ST_OUT;
				end else if (drain_q == 2'd3) begin
					drain_nx = drain_q;
				end
			end
			ST_OUT: begin
				// hold until the beat leaves, then next result
				if (out_ready) begin
					cmd.out_take = 1'b1;
					if (k_q == RBW'(ROWS_B - 1)) begin
						k_nx = '0;
						if (i_q == RAW'(ROWS_A - 1)) begin
							i_nx = '0;
							state_nx = ST_IDLE;
						end else begin
							i_nx = i_q + 1'b1;
							state_nx = ST_Y_MAC;
						end
					end else begin
						k_nx = k_q + 1'b1;
						state_nx = ST_Y_MAC;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end
endmodule

// ----- hdl/kfmv_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfmv_datapath
// Stores, separate MAC paths for the two passes, rounding and output register.
// ----------------------------------------------------------------------------
module kfmv_datapath import kfmv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_action,
	input  logic [9:0]         wr_index,
	input  logic signed [15:0] wr_value,
	input  logic               bias_en,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic               out_valid,
	output logic signed [31:0] out_result,
	output logic [3:0]         out_idx,
	output logic               out_last
);
	logic signed [15:0] a_mem [A_SIZE];
	logic signed [15:0] b_mem [B_SIZE];
	logic signed [15:0] bias_mem [Y_SIZE];
	logic signed [15:0] x_mem [X_SIZE];
	logic signed [36:0] p_mem [P_SIZE];

	logic signed [15:0] a_rd_s1, x_rd_s1, b_rd_s1, bias_rd_q;
	logic signed [36:0] p_rd_s1;
	logic               pm_s1, pc_s1, ym_s1, yc_s1;
	logic signed [31:0] pprod_s2;
	logic signed [52:0] yprod_s2;
	logic               pm_s2, pc_s2, ym_s2, yc_s2;
	logic signed [36:0] pacc_q;
	logic signed [63:0] yacc_q;
	logic [YW-1:0]      pos;
	logic signed [63:0] ysum, yrnd;
	logic signed [35:0] yq;

	// compare at 11 bits so that a store of 1024 entries keeps its bound
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (wr_action)
				ACT_WR_A:
					if (11'(wr_index) < 11'(A_SIZE)) a_mem[wr_index[AW-1:0]] <= wr_value;
				ACT_WR_B:
					if (11'(wr_index) < 11'(B_SIZE)) b_mem[wr_index[BW-1:0]] <= wr_value;
				ACT_WR_BIAS:
					if (11'(wr_index) < 11'(Y_SIZE)) bias_mem[wr_index[YW-1:0]] <= wr_value;
				ACT_PUSH_X:
					if (11'(wr_index) < 11'(X_SIZE)) x_mem[wr_index[XW-1:0]] <= wr_value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		a_rd_s1 <= a_mem[AW'(cmd.i * COLS_A + cmd.c)];
		x_rd_s1 <= x_mem[XW'(cmd.c * COLS_B + cmd.j)];
		b_rd_s1 <= b_mem[BW'(cmd.k * COLS_B + cmd.j)];
		p_rd_s1 <= p_mem[PW'(cmd.i * COLS_B + cmd.j)];
		bias_rd_q <= bias_mem[pos];
		if (cmd.p_wr) p_mem[PW'(cmd.i * COLS_B + cmd.j)] <= pacc_q;
	end
	assign pos = YW'(cmd.i * ROWS_B + cmd.k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_s1 <= 1'b0; pc_s1 <= 1'b0; ym_s1 <= 1'b0; yc_s1 <= 1'b0;
			pm_s2 <= 1'b0; pc_s2 <= 1'b0; ym_s2 <= 1'b0; yc_s2 <= 1'b0;
		end else begin
			pm_s1 <= cmd.p_mac; pc_s1 <= cmd.p_clr;
			ym_s1 <= cmd.y_mac; yc_s1 <= cmd.y_clr;
			pm_s2 <= pm_s1; pc_s2 <= pc_s1; ym_s2 <= ym_s1; yc_s2 <= yc_s1;
		end
	end

	always_ff @(posedge clk) begin
		pprod_s2 <= a_rd_s1 * x_rd_s1;
		yprod_s2 <= p_rd_s1 * b_rd_s1;
		if (pm_s2) pacc_q <= (pc_s2 ? 37'sd0 : pacc_q) + 37'(pprod_s2);
		if (ym_s2) yacc_q <= (yc_s2 ? 64'sd0 : yacc_q) + 64'(yprod_s2);
	end

	always_comb begin
		ysum = yacc_q + (bias_en ? (64'(bias_rd_q) <<< 28) : 64'sd0);
		yrnd = (ysum + (64'sd1 <<< 27)) >>> 28;
		yq = yrnd[35:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_last <= 1'b0;
			out_idx <= '0;
			out_result <= '0;
		end else if (cmd.y_fin) begin
			out_valid <= 1'b1;
			if (yq > 36'sh07FFFFFFF) out_result <= 32'sh7FFFFFFF;
			else if (yq < -36'sh080000000) out_result <= 32'sh80000000;
			else out_result <= yq[31:0];
			out_idx <= 4'(pos);
			out_last <= (pos == YW'(Y_SIZE - 1));
		end else if (cmd.out_take) begin
			out_valid <= 1'b0;
		end
	end
	assign sts.out_full = out_valid;
endmodule
